// ===== hw/rtl/tps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tps_pkg
// Shared constants for the trapezoid pulse source: default widths and
// configuration register indexes.
// ----------------------------------------------------------------------------
package tps_pkg;

    localparam int DEF_TIME_WIDTH  = 32;
    localparam int DEF_LEVEL_WIDTH = 16;
    localparam int CYCLE_WIDTH     = 16;
    localparam int REG_IDX_WIDTH   = 3;

    typedef logic [REG_IDX_WIDTH-1:0] reg_idx_t;

    localparam reg_idx_t REG_INITIAL_LEVEL = 3'd0;
    localparam reg_idx_t REG_PULSED_LEVEL  = 3'd1;
    localparam reg_idx_t REG_DELAY_TICKS   = 3'd2;
    localparam reg_idx_t REG_RISE_TICKS    = 3'd3;
    localparam reg_idx_t REG_FALL_TICKS    = 3'd4;
    localparam reg_idx_t REG_WIDTH_TICKS   = 3'd5;
    localparam reg_idx_t REG_PERIOD_TICKS  = 3'd6;
    localparam reg_idx_t REG_CYCLE_COUNT   = 3'd7;

endpackage
`default_nettype wire

// ===== hw/rtl/tps_mod_pipe.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tps_mod_pipe
// Pipelined restoring remainder: one dividend bit per stage, W stages.
// ----------------------------------------------------------------------------
module tps_mod_pipe
    import tps_pkg::*;
#(
    parameter int W = DEF_TIME_WIDTH
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         adv,
    input  wire logic         in_valid,
    input  wire logic [W-1:0] dividend,
    input  wire logic [W-1:0] divisor,
    input  wire logic         force_zero,
    output logic              out_valid,
    output logic [W-1:0]      remainder
);

    logic [W-1:0] vld_reg;
    logic [W-1:0] zero_reg;
    logic [W-1:0] rem_reg [W];
    logic [W-1:0] num_reg [W];

    genvar k;
    generate
        for (k = 0; k < W; k++)
        begin : g_stage
            logic         pv;
            logic         pz;
            logic [W-1:0] prem;
            logic [W-1:0] pnum;
            logic [W:0]   trial;
            logic         ge;
            logic [W:0]   rem_next;

            if (k == 0)
            begin : g_first
                assign pv   = in_valid;
                assign pz   = force_zero;
                assign prem = '0;
                assign pnum = dividend;
            end
            else
            begin : g_rest
                assign pv   = vld_reg[k-1];
                assign pz   = zero_reg[k-1];
                assign prem = rem_reg[k-1];
                assign pnum = num_reg[k-1];
            end

            assign trial    = {prem, pnum[W-1]};
            assign ge       = (trial >= {1'b0, divisor});
            assign rem_next = ge ? (trial - {1'b0, divisor}) : trial;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k] <= 1'b0;
                end
                else if (adv)
                begin
                    vld_reg[k] <= pv;
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    zero_reg[k] <= pz;
                    rem_reg[k]  <= rem_next[W-1:0];
                    num_reg[k]  <= {pnum[W-2:0], 1'b0};
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[W-1];
    assign remainder = zero_reg[W-1] ? '0 : rem_reg[W-1];

endmodule
`default_nettype wire

// ===== hw/rtl/tps_ramp_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tps_ramp_div
// Pipelined quotient of product / span. The quotient is known to fit LW bits,
// so the top TW product bits seed the remainder and LW stages remain.
// ----------------------------------------------------------------------------
module tps_ramp_div
    import tps_pkg::*;
#(
    parameter int TW = DEF_TIME_WIDTH,
    parameter int LW = DEF_LEVEL_WIDTH
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            adv,
    input  wire logic            in_valid,
    input  wire logic [TW+LW-1:0] product,
    input  wire logic [TW-1:0]   span,
    input  wire logic [LW-1:0]   start,
    input  wire logic            neg,
    output logic                 out_valid,
    output logic [LW-1:0]        quotient,
    output logic [LW-1:0]        out_start,
    output logic                 out_neg
);

    logic [LW-1:0] vld_reg;
    logic [LW-1:0] neg_reg;
    logic [TW-1:0] rem_reg   [LW];
    logic [LW-1:0] num_reg   [LW];
    logic [LW-1:0] q_reg     [LW];
    logic [TW-1:0] span_reg  [LW];
    logic [LW-1:0] start_reg [LW];

    genvar k;
    generate
        for (k = 0; k < LW; k++)
        begin : g_stage
            logic          pv;
            logic          pn;
            logic [TW-1:0] prem;
            logic [LW-1:0] pnum;
            logic [LW-1:0] pq;
            logic [TW-1:0] pspan;
            logic [LW-1:0] pstart;
            logic [TW:0]   trial;
            logic          ge;
            logic [TW:0]   rem_next;

            if (k == 0)
            begin : g_first
                assign pv     = in_valid;
                assign pn     = neg;
                assign prem   = product[TW+LW-1:LW];
                assign pnum   = product[LW-1:0];
                assign pq     = '0;
                assign pspan  = span;
                assign pstart = start;
            end
            else
            begin : g_rest
                assign pv     = vld_reg[k-1];
                assign pn     = neg_reg[k-1];
                assign prem   = rem_reg[k-1];
                assign pnum   = num_reg[k-1];
                assign pq     = q_reg[k-1];
                assign pspan  = span_reg[k-1];
                assign pstart = start_reg[k-1];
            end

            assign trial    = {prem, pnum[LW-1]};
            assign ge       = (trial >= {1'b0, pspan});
            assign rem_next = ge ? (trial - {1'b0, pspan}) : trial;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k] <= 1'b0;
                end
                else if (adv)
                begin
                    vld_reg[k] <= pv;
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    neg_reg[k]   <= pn;
                    rem_reg[k]   <= rem_next[TW-1:0];
                    num_reg[k]   <= {pnum[LW-2:0], 1'b0};
                    q_reg[k]     <= {pq[LW-2:0], ge};
                    span_reg[k]  <= pspan;
                    start_reg[k] <= pstart;
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[LW-1];
    assign quotient  = q_reg[LW-1];
    assign out_start = start_reg[LW-1];
    assign out_neg   = neg_reg[LW-1];

endmodule
`default_nettype wire

// ===== hw/rtl/trapezoid_pulse_source.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trapezoid_pulse_source
// Periodic trapezoid (SPICE PULSE) level for each incoming time stamp.
//
// Input channel: in_valid / in_stall with sample_time. Output channel:
// out_valid / out_stall with level. Registers are written through
// write_enable / reg_index / write_data; the user must do so only while
// no transaction is in flight; the block does not enforce this. Stages:
// one multiply stage, TIME_WIDTH stages of the phase remainder pipeline,
// four compare/select stages, one ramp multiply, LEVEL_WIDTH stages of
// the ramp quotient pipeline and one output add.
// Throughput is one transaction per cycle unless the receiver stalls.
// Reset clears all pipeline valid bits and loads register defaults
// (period 1, all others 0).
// When the receiver stalls with a result waiting, the whole pipeline
// freezes and in_stall is raised; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module trapezoid_pulse_source
    import tps_pkg::*;
#(
    parameter int TIME_WIDTH  = DEF_TIME_WIDTH,
    parameter int LEVEL_WIDTH = DEF_LEVEL_WIDTH,
    localparam int CFG_WIDTH  = (TIME_WIDTH > LEVEL_WIDTH) ?
        ((TIME_WIDTH > CYCLE_WIDTH) ? TIME_WIDTH : CYCLE_WIDTH) :
        ((LEVEL_WIDTH > CYCLE_WIDTH) ? LEVEL_WIDTH : CYCLE_WIDTH)
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          write_enable,
    input  wire logic [REG_IDX_WIDTH-1:0]      reg_index,
    input  wire logic [CFG_WIDTH-1:0]          write_data,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [TIME_WIDTH-1:0]         sample_time,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic signed [LEVEL_WIDTH-1:0]      level
);

    localparam int TW = TIME_WIDTH;
    localparam int LW = LEVEL_WIDTH;

    // configuration
    logic signed [LW-1:0]    init_reg;
    logic signed [LW-1:0]    puls_reg;
    logic [TW-1:0]           delay_reg;
    logic [TW-1:0]           rise_reg;
    logic [TW-1:0]           fall_reg;
    logic [TW-1:0]           width_reg;
    logic [TW-1:0]           period_reg;
    logic [CYCLE_WIDTH-1:0]  cycles_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg   <= '0;
            puls_reg   <= '0;
            delay_reg  <= '0;
            rise_reg   <= '0;
            fall_reg   <= '0;
            width_reg  <= '0;
            period_reg <= TW'(1);
            cycles_reg <= '0;
        end
        else if (write_enable)
        begin
            unique case (reg_index)
                REG_INITIAL_LEVEL: init_reg   <= write_data[LW-1:0];
                REG_PULSED_LEVEL:  puls_reg   <= write_data[LW-1:0];
                REG_DELAY_TICKS:   delay_reg  <= write_data[TW-1:0];
                REG_RISE_TICKS:    rise_reg   <= write_data[TW-1:0];
                REG_FALL_TICKS:    fall_reg   <= write_data[TW-1:0];
                REG_WIDTH_TICKS:   width_reg  <= write_data[TW-1:0];
                REG_PERIOD_TICKS:  period_reg <= write_data[TW-1:0];
                REG_CYCLE_COUNT:   cycles_reg <= write_data[CYCLE_WIDTH-1:0];
                default:           ;
            endcase
        end
    end

    logic adv;
    assign adv      = !out_valid || !out_stall;
    assign in_stall = !adv;

    // ramp magnitude; |puls - init| always fits LW bits
    logic signed [LW:0] diff;
    logic [LW:0]        diff_abs;
    logic [LW-1:0]      mag;
    logic               puls_lt_init;
    assign diff         = $signed({puls_reg[LW-1], puls_reg}) -
                          $signed({init_reg[LW-1], init_reg});
    assign puls_lt_init = diff[LW];
    assign diff_abs     = puls_lt_init ? (~diff + 1'b1) : diff;
    assign mag          = diff_abs[LW-1:0];

    // S1: end of the last cycle
    logic                      s1_vld_reg;
    logic [TW-1:0]             s1_time_reg;
    logic [TW+CYCLE_WIDTH-1:0] s1_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= 1'b0;
        else if (adv)
            s1_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_time_reg  <= sample_time;
            s1_limit_reg <= period_reg * cycles_reg;
        end
    end

    logic          force_zero;
    logic          m_vld;
    logic [TW-1:0] phase;
    assign force_zero = (period_reg == '0) ||
                        ({{CYCLE_WIDTH{1'b0}}, s1_time_reg} > s1_limit_reg);

    tps_mod_pipe #(.W(TW)) u_mod (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .in_valid   (s1_vld_reg),
        .dividend   (s1_time_reg),
        .divisor    (period_reg),
        .force_zero (force_zero),
        .out_valid  (m_vld),
        .remainder  (phase)
    );

    // S2: delay
    logic          s2_vld_reg;
    logic          s2_le_reg;
    logic [TW-1:0] s2_u_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_vld_reg <= 1'b0;
        else if (adv)
            s2_vld_reg <= m_vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_le_reg <= (phase <= delay_reg);
            s2_u_reg  <= phase - delay_reg;
        end
    end

    // S3: rise
    logic          s3_vld_reg;
    logic          s3_le_reg;
    logic          s3_rise_reg;
    logic [TW-1:0] s3_u_reg;
    logic [TW-1:0] s3_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_vld_reg <= 1'b0;
        else if (adv)
            s3_vld_reg <= s2_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_le_reg   <= s2_le_reg;
            s3_rise_reg <= (s2_u_reg < rise_reg);
            s3_u_reg    <= s2_u_reg;
            s3_v_reg    <= s2_u_reg - rise_reg;
        end
    end

    // S4: width
    logic          s4_vld_reg;
    logic          s4_le_reg;
    logic          s4_rise_reg;
    logic          s4_hold_reg;
    logic [TW-1:0] s4_u_reg;
    logic [TW-1:0] s4_w_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_vld_reg <= 1'b0;
        else if (adv)
            s4_vld_reg <= s3_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_le_reg   <= s3_le_reg;
            s4_rise_reg <= s3_rise_reg;
            s4_hold_reg <= (s3_v_reg <= width_reg);
            s4_u_reg    <= s3_u_reg;
            s4_w_reg    <= s3_v_reg - width_reg;
        end
    end

    // S5: segment select; flat segments run as a ramp of zero magnitude
    logic          s5_vld_reg;
    logic [TW-1:0] s5_elapsed_reg;
    logic [TW-1:0] s5_span_reg;
    logic [LW-1:0] s5_start_reg;
    logic [LW-1:0] s5_mag_reg;
    logic          s5_neg_reg;

    logic [TW-1:0] sel_elapsed;
    logic [TW-1:0] sel_span;
    logic [LW-1:0] sel_start;
    logic [LW-1:0] sel_mag;
    logic          sel_neg;

    always_comb
    begin
        sel_elapsed = '0;
        sel_span    = TW'(1);
        sel_start   = init_reg;
        sel_mag     = '0;
        sel_neg     = 1'b0;
        if (s4_le_reg)
        begin
            sel_start = init_reg;
        end
        else if (s4_rise_reg)
        begin
            sel_elapsed = s4_u_reg;
            sel_span    = rise_reg;
            sel_start   = init_reg;
            sel_mag     = mag;
            sel_neg     = puls_lt_init;
        end
        else if (s4_hold_reg)
        begin
            sel_start = puls_reg;
        end
        else if (s4_w_reg < fall_reg)
        begin
            sel_elapsed = s4_w_reg;
            sel_span    = fall_reg;
            sel_start   = puls_reg;
            sel_mag     = mag;
            sel_neg     = !puls_lt_init;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s5_vld_reg <= 1'b0;
        else if (adv)
            s5_vld_reg <= s4_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_elapsed_reg <= sel_elapsed;
            s5_span_reg    <= sel_span;
            s5_start_reg   <= sel_start;
            s5_mag_reg     <= sel_mag;
            s5_neg_reg     <= sel_neg;
        end
    end

    // S6: ramp product
    logic             s6_vld_reg;
    logic [TW+LW-1:0] s6_prod_reg;
    logic [TW-1:0]    s6_span_reg;
    logic [LW-1:0]    s6_start_reg;
    logic             s6_neg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s6_vld_reg <= 1'b0;
        else if (adv)
            s6_vld_reg <= s5_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s6_prod_reg  <= s5_elapsed_reg * s5_mag_reg;
            s6_span_reg  <= s5_span_reg;
            s6_start_reg <= s5_start_reg;
            s6_neg_reg   <= s5_neg_reg;
        end
    end

    logic          d_vld;
    logic [LW-1:0] d_q;
    logic [LW-1:0] d_start;
    logic          d_neg;

    tps_ramp_div #(.TW(TW), .LW(LW)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s6_vld_reg),
        .product   (s6_prod_reg),
        .span      (s6_span_reg),
        .start     (s6_start_reg),
        .neg       (s6_neg_reg),
        .out_valid (d_vld),
        .quotient  (d_q),
        .out_start (d_start),
        .out_neg   (d_neg)
    );

    // output stage
    logic          out_vld_reg;
    logic [LW-1:0] level_reg;
    logic [LW-1:0] level_next;

    assign level_next = d_neg ? (d_start - d_q) : (d_start + d_q);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (adv)
            out_vld_reg <= d_vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            level_reg <= level_next;
    end

    assign out_valid = out_vld_reg;
    assign level     = level_reg;

endmodule
`default_nettype wire
